[src/kqsb_pkg.sv]
// Shared types and constants for the shared-buffer multi-queue block.
package kqsb_pkg;

    localparam int DATA_W = 32;
    localparam int SEL_W  = 3;

    typedef enum logic
    {
        MODE_ENQ = 1'b0,
        MODE_DEQ = 1'b1
    } mode_t;

    typedef enum logic [1:0]
    {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2
    } status_t;

    typedef struct packed
    {
        status_t             status;
        logic [DATA_W-1:0]   value;
    } result_t;

endpackage

[src/kqsb_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module kqsb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic                                  re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[src/kqsb_engine.sv]
// Queue controller: pointer bookkeeping over the queue, link and data RAMs.
module kqsb_engine #(
    parameter int ENTRIES = 64,
    parameter int QUEUES  = 8,
    localparam int PW = $clog2(ENTRIES + 1),
    localparam int AW = $clog2(ENTRIES),
    localparam int QW = (QUEUES > 1) ? $clog2(QUEUES) : 1
) (
    input  logic                         clk,
    input  logic                         rst_n,
    // item in
    input  logic                         in_valid,
    output logic                         in_ready,
    input  kqsb_pkg::mode_t              in_mode,
    input  logic [kqsb_pkg::SEL_W-1:0]   in_queue_sel,
    input  logic [kqsb_pkg::DATA_W-1:0]  in_value,
    // result out
    output logic                         res_valid,
    input  logic                         res_ready,
    output kqsb_pkg::result_t            res,
    // queue RAM: {head, tail}
    output logic                         qram_we,
    output logic [QW-1:0]                qram_waddr,
    output logic [2*PW-1:0]              qram_wdata,
    output logic                         qram_re,
    output logic [QW-1:0]                qram_raddr,
    input  logic [2*PW-1:0]              qram_rdata,
    // link RAM
    output logic                         link_we,
    output logic [AW-1:0]                link_waddr,
    output logic [PW-1:0]                link_wdata,
    output logic                         link_re,
    output logic [AW-1:0]                link_raddr,
    input  logic [PW-1:0]                link_rdata,
    // data RAM
    output logic                         data_we,
    output logic [AW-1:0]                data_waddr,
    output logic [kqsb_pkg::DATA_W-1:0]  data_wdata,
    output logic                         data_re,
    output logic [AW-1:0]                data_raddr,
    input  logic [kqsb_pkg::DATA_W-1:0]  data_rdata
);

    localparam int QN = 1 << QW;
    localparam logic [PW-1:0] PTR_NULL = PW'(ENTRIES);

    typedef enum logic [1:0]
    {
        S_IDLE,
        S_LINK,
        S_WB
    } state_t;

    state_t                        state_reg, state_next;
    kqsb_pkg::mode_t               mode_reg, mode_next;
    logic [kqsb_pkg::SEL_W-1:0]    q_reg, q_next;
    logic [kqsb_pkg::DATA_W-1:0]   val_reg, val_next;
    logic                          range_reg, range_next;
    logic [PW-1:0]                 free_head_reg, free_head_next;
    // entries at or above fresh_reg were never allocated; they form the
    // tail of the free list in index order and their link is index + 1
    logic [PW-1:0]                 fresh_reg, fresh_next;
    logic [QN-1:0]                 qvalid_reg, qvalid_next;

    logic [QW-1:0]  q_idx;
    logic [PW-1:0]  head, tail;
    logic           q_busy;
    logic           enq_ok, deq_ok;
    logic           fresh_hit;
    logic           commit;
    logic           accept;

    assign q_idx     = QW'(q_reg);
    assign head      = qram_rdata[2*PW-1:PW];
    assign tail      = qram_rdata[PW-1:0];
    assign q_busy    = qvalid_reg[q_idx];
    assign enq_ok    = (mode_reg == kqsb_pkg::MODE_ENQ) && range_reg && (free_head_reg != PTR_NULL);
    assign deq_ok    = (mode_reg == kqsb_pkg::MODE_DEQ) && range_reg && q_busy;
    assign fresh_hit = (free_head_reg == fresh_reg);

    assign in_ready  = (state_reg == S_IDLE);
    assign accept    = in_valid && in_ready;
    assign res_valid = (state_reg == S_WB);
    assign commit    = res_valid && res_ready;

    // queue entry is fetched straight off the input transfer
    assign qram_re    = accept;
    assign qram_raddr = QW'(in_queue_sel);

    assign link_re    = (state_reg == S_LINK);
    assign link_raddr = (mode_reg == kqsb_pkg::MODE_ENQ) ? AW'(free_head_reg) : AW'(head);
    assign data_re    = (state_reg == S_LINK);
    assign data_raddr = AW'(head);

    always_comb
    begin
        state_next     = state_reg;
        mode_next      = mode_reg;
        q_next         = q_reg;
        val_next       = val_reg;
        range_next     = range_reg;
        free_head_next = free_head_reg;
        fresh_next     = fresh_reg;
        qvalid_next    = qvalid_reg;

        qram_we    = 1'b0;
        qram_waddr = q_idx;
        qram_wdata = {head, free_head_reg};
        link_we    = 1'b0;
        link_waddr = AW'(tail);
        link_wdata = free_head_reg;
        data_we    = 1'b0;
        data_waddr = AW'(free_head_reg);
        data_wdata = val_reg;

        res.status = (mode_reg == kqsb_pkg::MODE_ENQ)
                     ? (enq_ok ? kqsb_pkg::ST_OK : kqsb_pkg::ST_OVERFLOW)
                     : (deq_ok ? kqsb_pkg::ST_OK : kqsb_pkg::ST_UNDERFLOW);
        res.value  = deq_ok ? data_rdata : '0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    mode_next  = in_mode;
                    q_next     = in_queue_sel;
                    val_next   = in_value;
                    range_next = (32'(in_queue_sel) < QUEUES);
                    state_next = S_LINK;
                end
            end
            S_LINK:
            begin
                state_next = S_WB;
            end
            S_WB:
            begin
                if (commit)
                begin
                    state_next = S_IDLE;
                    if (enq_ok)
                    begin
                        // append after the tail; the new tail's link is left stale,
                        // a dequeue detects the last entry by head == tail
                        link_we        = q_busy;
                        link_waddr     = AW'(tail);
                        link_wdata     = free_head_reg;
                        qram_we        = 1'b1;
                        qram_wdata     = {(q_busy ? head : free_head_reg), free_head_reg};
                        data_we        = 1'b1;
                        qvalid_next[q_idx] = 1'b1;
                        free_head_next = fresh_hit ? (free_head_reg + PW'(1)) : link_rdata;
                        if (fresh_hit)
                        begin
                            fresh_next = fresh_reg + PW'(1);
                        end
                    end
                    else if (deq_ok)
                    begin
                        link_we        = 1'b1;
                        link_waddr     = AW'(head);
                        link_wdata     = free_head_reg;
                        qram_we        = 1'b1;
                        qram_wdata     = {link_rdata, tail};
                        qvalid_next[q_idx] = (head != tail);
                        free_head_next = head;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            mode_reg      <= kqsb_pkg::MODE_ENQ;
            q_reg         <= '0;
            val_reg       <= '0;
            range_reg     <= 1'b0;
            free_head_reg <= '0;
            fresh_reg     <= '0;
            qvalid_reg    <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            mode_reg      <= mode_next;
            q_reg         <= q_next;
            val_reg       <= val_next;
            range_reg     <= range_next;
            free_head_reg <= free_head_next;
            fresh_reg     <= fresh_next;
            qvalid_reg    <= qvalid_next;
        end
    end

    a_free_head_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (free_head_reg == PTR_NULL) || (free_head_reg <= fresh_reg))
        else $error("free head points into never-allocated region");

    a_fresh_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fresh_reg <= PTR_NULL)
        else $error("fresh count beyond entry count");

    a_accept_seq: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == S_LINK) && $stable(free_head_reg))
        else $error("accepted transfer did not start the link fetch");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res_ready) |=> res_valid && $stable(free_head_reg) && $stable(qvalid_reg))
        else $error("state changed while result stalled");

endmodule

[src/k_queues_shared_buffer.sv]
// Several FIFO queues sharing one entry store through linked lists and a free list.
// Items are taken one at a time, a new one only after the last is written back.
// Each goes through a queue RAM read, a link/data RAM read and a write-back into the
// output register on m_*; the write-back waits while it is full and not being taken.
// Reset: asynchronous, active low; all queues empty, free list holds every entry in order.
// No clearing pass: unallocated entries are tracked by a fill count.
module k_queues_shared_buffer #(
    parameter int ENTRIES = 64,
    parameter int QUEUES  = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // [2:0] queue_sel, [34:3] value_in, [39:35] zero
    input  logic        s_tuser,   // [0] mode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] value_out
    output logic [1:0]  m_tuser    // [1:0] status
);

    localparam int PW = $clog2(ENTRIES + 1);
    localparam int AW = $clog2(ENTRIES);
    localparam int QW = (QUEUES > 1) ? $clog2(QUEUES) : 1;

    logic                         res_valid, res_ready;
    kqsb_pkg::result_t            res;
    logic                         out_valid_reg, out_valid_next;
    kqsb_pkg::result_t            out_res_reg, out_res_next;

    logic                         qram_we, qram_re;
    logic [QW-1:0]                qram_waddr, qram_raddr;
    logic [2*PW-1:0]              qram_wdata, qram_rdata;
    logic                         link_we, link_re;
    logic [AW-1:0]                link_waddr, link_raddr;
    logic [PW-1:0]                link_wdata, link_rdata;
    logic                         data_we, data_re;
    logic [AW-1:0]                data_waddr, data_raddr;
    logic [kqsb_pkg::DATA_W-1:0]  data_wdata, data_rdata;

    kqsb_engine #(
        .ENTRIES (ENTRIES),
        .QUEUES  (QUEUES)
    ) u_engine (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .in_mode      (kqsb_pkg::mode_t'(s_tuser)),
        .in_queue_sel (s_tdata[2:0]),
        .in_value     (s_tdata[34:3]),
        .res_valid    (res_valid),
        .res_ready    (res_ready),
        .res          (res),
        .qram_we      (qram_we),
        .qram_waddr   (qram_waddr),
        .qram_wdata   (qram_wdata),
        .qram_re      (qram_re),
        .qram_raddr   (qram_raddr),
        .qram_rdata   (qram_rdata),
        .link_we      (link_we),
        .link_waddr   (link_waddr),
        .link_wdata   (link_wdata),
        .link_re      (link_re),
        .link_raddr   (link_raddr),
        .link_rdata   (link_rdata),
        .data_we      (data_we),
        .data_waddr   (data_waddr),
        .data_wdata   (data_wdata),
        .data_re      (data_re),
        .data_raddr   (data_raddr),
        .data_rdata   (data_rdata)
    );

    kqsb_ram #(.WIDTH(2*PW), .DEPTH(QUEUES)) u_qram (
        .clk   (clk),
        .we    (qram_we),
        .waddr (qram_waddr),
        .wdata (qram_wdata),
        .re    (qram_re),
        .raddr (qram_raddr),
        .rdata (qram_rdata)
    );

    kqsb_ram #(.WIDTH(PW), .DEPTH(ENTRIES)) u_link_ram (
        .clk   (clk),
        .we    (link_we),
        .waddr (link_waddr),
        .wdata (link_wdata),
        .re    (link_re),
        .raddr (link_raddr),
        .rdata (link_rdata)
    );

    kqsb_ram #(.WIDTH(kqsb_pkg::DATA_W), .DEPTH(ENTRIES)) u_data_ram (
        .clk   (clk),
        .we    (data_we),
        .waddr (data_waddr),
        .wdata (data_wdata),
        .re    (data_re),
        .raddr (data_raddr),
        .rdata (data_rdata)
    );

    // output register: load when empty or draining this cycle
    assign res_ready = !out_valid_reg || m_tready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_res_next   = out_res_reg;
        if (res_valid && res_ready)
        begin
            out_valid_next = 1'b1;
            out_res_next   = res;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            out_res_reg   <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            out_res_reg   <= out_res_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_res_reg.value;
    assign m_tuser  = out_res_reg.status;

endmodule

[sim/tb.sv]
// Self-checking testbench for the shared-buffer multi-queue block.
module tb;

    localparam int ENTRIES = 64;
    localparam int QUEUES  = 8;
    localparam logic [6:0] NIL = 7'(ENTRIES);

    typedef struct packed
    {
        kqsb_pkg::mode_t mode;
        logic [2:0]      qsel;
        logic [31:0]     val;
    } queue_op_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata  = '0;   // [2:0] queue_sel, [34:3] value_in, [39:35] zero
    logic        s_tuser  = 1'b0; // [0] mode
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;         // [31:0] value_out
    logic [1:0]  m_tuser;         // [1:0] status

    k_queues_shared_buffer #(.ENTRIES(ENTRIES), .QUEUES(QUEUES)) dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // predicted state of the linked-list store
    logic [31:0] slot_value [ENTRIES];
    logic [6:0]  slot_next  [ENTRIES];
    logic [6:0]  q_head     [QUEUES];
    logic [6:0]  q_tail     [QUEUES];
    logic [6:0]  free_top;

    // occupancy as seen by the generator, used to aim dequeues at live queues
    int gen_depth [QUEUES];
    int gen_total;

    queue_op_t           op_fifo[$];
    kqsb_pkg::result_t   pending_results[$];
    queue_op_t           sent_op;
    kqsb_pkg::result_t   want;

    int tx_idle_pct  = 0;
    int rx_stall_pct = 0;
    logic hold_trigger = 1'b0;
    logic rx_hold = 1'b0;

    int err_count = 0;
    int n_sent    = 0;
    int n_results = 0;
    int n_ovf     = 0;
    int n_udf     = 0;
    int n_deq_ok  = 0;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
    end

    initial
    begin
        #400000;
        $display("timeout: %0d items sent, %0d results outstanding", n_sent,
                 pending_results.size());
        $display("[k_queues_shared_buffer] ERROR");
        $finish;
    end

    task automatic flag_mismatch(input string msg);
        $display("mismatch @%0t: %s", $time, msg);
        err_count++;
    endtask

    function automatic kqsb_pkg::result_t queue_op_apply(input queue_op_t op);
        kqsb_pkg::result_t r;
        logic [6:0]        slot;
        r.status = kqsb_pkg::ST_OK;
        r.value  = '0;
        if (op.mode == kqsb_pkg::MODE_ENQ)
        begin
            if (free_top >= NIL)
                r.status = kqsb_pkg::ST_OVERFLOW;
            else
            begin
                slot     = free_top;
                free_top = slot_next[slot];
                if (q_head[op.qsel] >= NIL)
                    q_head[op.qsel] = slot;
                else
                    slot_next[q_tail[op.qsel]] = slot;
                slot_next[slot]  = NIL;
                q_tail[op.qsel]  = slot;
                slot_value[slot] = op.val;
            end
        end
        else
        begin
            if (q_head[op.qsel] >= NIL)
                r.status = kqsb_pkg::ST_UNDERFLOW;
            else
            begin
                slot            = q_head[op.qsel];
                q_head[op.qsel] = slot_next[slot];
                slot_next[slot] = free_top;
                free_top        = slot;
                r.value         = slot_value[slot];
            end
        end
        return r;
    endfunction

    task automatic push_op(input kqsb_pkg::mode_t mode, input int q, input logic [31:0] val);
        queue_op_t op;
        op.mode = mode;
        op.qsel = 3'(q);
        op.val  = val;
        if (mode == kqsb_pkg::MODE_ENQ && gen_total < ENTRIES)
        begin
            gen_depth[q]++;
            gen_total++;
        end
        else if (mode == kqsb_pkg::MODE_DEQ && gen_depth[q] != 0)
        begin
            gen_depth[q]--;
            gen_total--;
        end
        op_fifo.push_back(op);
    endtask

    task automatic gen_ops(input int count, input int enq_pct);
        int          q;
        int          start;
        logic        found;
        logic [31:0] val;
        for (int i = 0; i < count; i++)
        begin
            q   = $urandom_range(QUEUES - 1);
            val = $urandom;
            if ($urandom_range(7) == 0)
            begin
                case ($urandom_range(3))
                    0: val = 32'h0000_0000;
                    1: val = 32'hFFFF_FFFF;
                    2: val = 32'h7FFF_FFFF;
                    default: val = 32'h8000_0000;
                endcase
            end
            if ($urandom_range(99) < enq_pct)
                push_op(kqsb_pkg::MODE_ENQ, q, val);
            else
            begin
                // mostly hit a queue that holds something; the rest may underflow
                if (gen_total != 0 && $urandom_range(99) < 85)
                begin
                    start = $urandom_range(QUEUES - 1);
                    found = 1'b0;
                    for (int k = 0; k < QUEUES; k++)
                    begin
                        if (!found && gen_depth[(start + k) % QUEUES] != 0)
                        begin
                            q     = (start + k) % QUEUES;
                            found = 1'b1;
                        end
                    end
                end
                push_op(kqsb_pkg::MODE_DEQ, q, val);
            end
        end
    endtask

    task automatic wait_idle;
        while (op_fifo.size() != 0 || s_tvalid || pending_results.size() != 0)
            @(posedge clk);
    endtask

    // sender
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= 1'b0;
        end
        else if (!s_tvalid || s_tready)
        begin
            if (s_tvalid)
            begin
                pending_results.push_back(queue_op_apply(sent_op));
                n_sent++;
            end
            if (op_fifo.size() != 0 && $urandom_range(99) >= tx_idle_pct)
            begin
                sent_op = op_fifo.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= {5'b0, sent_op.val, sent_op.qsel};
                s_tuser  <= sent_op.mode;
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // receiver and checker
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
            begin
                n_results++;
                if (pending_results.size() == 0)
                    flag_mismatch($sformatf("unexpected result status=%0d value=%h",
                                            m_tuser, m_tdata));
                else
                begin
                    want = pending_results.pop_front();
                    if (m_tuser !== want.status)
                        flag_mismatch($sformatf("result %0d status %0d, want %0d",
                                                n_results, m_tuser, want.status));
                    if (m_tdata !== want.value)
                        flag_mismatch($sformatf("result %0d value %h, want %h",
                                                n_results, m_tdata, want.value));
                    if (want.status == kqsb_pkg::ST_OVERFLOW)
                        n_ovf++;
                    else if (want.status == kqsb_pkg::ST_UNDERFLOW)
                        n_udf++;
                    else if (want.value !== 32'h0 || m_tdata !== 32'h0)
                        n_deq_ok++;
                end
            end
            m_tready <= !rx_hold && ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // long receiver hold-off so the block backs up into its input
    initial
    begin : rx_holdoff
        wait (hold_trigger);
        @(posedge clk);
        rx_hold <= 1'b1;
        repeat (400) @(posedge clk);
        rx_hold <= 1'b0;
    end

    initial
    begin : stimulus
        for (int i = 0; i < ENTRIES; i++)
        begin
            slot_value[i] = '0;
            slot_next[i]  = 7'(i + 1);
        end
        for (int i = 0; i < QUEUES; i++)
        begin
            q_head[i]    = NIL;
            q_tail[i]    = NIL;
            gen_depth[i] = 0;
        end
        free_top  = '0;
        gen_total = 0;

        while (!rst_n)
            @(posedge clk);

        // directed: field extremes, empty queues, order within and across queues
        push_op(kqsb_pkg::MODE_DEQ, 0, 32'hFFFF_FFFF);
        push_op(kqsb_pkg::MODE_DEQ, 7, 32'h0);
        push_op(kqsb_pkg::MODE_ENQ, 0, 32'h7FFF_FFFF);
        push_op(kqsb_pkg::MODE_ENQ, 7, 32'h8000_0000);
        push_op(kqsb_pkg::MODE_ENQ, 3, 32'h0000_0000);
        push_op(kqsb_pkg::MODE_ENQ, 3, 32'hFFFF_FFFF);
        push_op(kqsb_pkg::MODE_ENQ, 3, 32'h5555_5555);
        push_op(kqsb_pkg::MODE_DEQ, 3, 32'h0);
        push_op(kqsb_pkg::MODE_DEQ, 3, 32'h0);
        push_op(kqsb_pkg::MODE_DEQ, 3, 32'h0);
        push_op(kqsb_pkg::MODE_DEQ, 3, 32'h0);
        push_op(kqsb_pkg::MODE_DEQ, 0, 32'h0);
        push_op(kqsb_pkg::MODE_DEQ, 7, 32'h0);
        push_op(kqsb_pkg::MODE_DEQ, 5, 32'h0);
        // queue drained then refilled: stale tail must not be followed
        push_op(kqsb_pkg::MODE_ENQ, 1, 32'hA5A5_A5A5);
        push_op(kqsb_pkg::MODE_DEQ, 1, 32'h0);
        push_op(kqsb_pkg::MODE_ENQ, 1, 32'h5A5A_5A5A);
        push_op(kqsb_pkg::MODE_ENQ, 1, 32'h1234_5678);
        push_op(kqsb_pkg::MODE_ENQ, 6, 32'hDEAD_BEEF);
        push_op(kqsb_pkg::MODE_DEQ, 1, 32'h0);
        push_op(kqsb_pkg::MODE_DEQ, 6, 32'h0);
        push_op(kqsb_pkg::MODE_DEQ, 1, 32'h0);
        push_op(kqsb_pkg::MODE_DEQ, 2, 32'h0);
        push_op(kqsb_pkg::MODE_DEQ, 4, 32'h0);
        wait_idle();

        gen_ops(100, 60);
        wait_idle();

        tx_idle_pct = 47;
        gen_ops(80, 50);
        wait_idle();

        tx_idle_pct  = 0;
        rx_stall_pct = 47;
        gen_ops(80, 50);
        wait_idle();

        tx_idle_pct  = 16;
        rx_stall_pct = 16;
        gen_ops(80, 50);
        wait_idle();

        // back-pressure: output held while input keeps coming
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        gen_ops(80, 70);
        hold_trigger = 1'b1;
        wait_idle();

        // fill past capacity, then empty everything and beyond
        tx_idle_pct  = 16;
        rx_stall_pct = 16;
        gen_ops(80, 100);
        wait_idle();
        gen_ops(90, 5);
        wait_idle();

        repeat (20) @(posedge clk);
        $display("%0d operations over 8 queues, %0d results: %0d dequeues with data,",
                 n_sent, n_results, n_deq_ok);
        $display("%0d overflows, %0d underflows, stalls on both sides and one long hold-off",
                 n_ovf, n_udf);
        if (err_count == 0 && pending_results.size() == 0)
            $display("[k_queues_shared_buffer] OK");
        else
            $display("[k_queues_shared_buffer] ERROR");
        $finish;
    end

endmodule
